FILE: hdl/tmd_pkg.sv
// Shared types and constants for the thruster mixer with deadband PWM mapping.
// Holds field widths, sequencer states, register indexes and divider handshake structs.
// No dependencies.
package tmd_pkg;

  localparam int NUM_THRUSTERS = 7;
  localparam int NUM_MAPS      = 5;
  localparam int CMD_W         = 11;
  localparam int CUR_W         = 16;
  localparam int PWM_W         = 12;
  localparam int THR_W         = 13;
  localparam int FS_W          = 10;
  localparam int PROD_W        = 23;
  localparam int MAG_W         = 22;
  localparam int DIV_STEPS     = 22;
  localparam int S_TDATA_W     = 112;
  localparam int M_TDATA_W     = 88;
  localparam int CFG_W         = 16;

  localparam logic [PWM_W-1:0]        STOP_COUNT = 12'd302;
  localparam logic signed [THR_W-1:0] THRUST_DB  = 13'sd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_DONE
  } tmd_state_t;

  typedef enum logic [2:0] {
    REG_CMD_DB,
    REG_FULL_SCALE,
    REG_PWM_MIN,
    REG_PWM_DB_LOW,
    REG_PWM_DB_HIGH,
    REG_PWM_MAX,
    REG_CUR_LIMIT,
    REG_TRIP_COUNT
  } tmd_reg_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] num;
    logic [FS_W-1:0]          den;
  } tmd_div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [THR_W-1:0] quot;
  } tmd_div_rsp_t;

endpackage

FILE: hdl/tmd_fdiv.sv
// Iterative floor divider: signed numerator by positive denominator, one bit a cycle.
// Depends on tmd_pkg for widths and the request/response structs.
module tmd_fdiv import tmd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  tmd_div_req_t req,
  output tmd_div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [4:0]        cnt;
  logic [MAG_W-1:0]  acc;
  logic [FS_W-1:0]   rem;
  logic [FS_W-1:0]   den;
  logic              neg;
  logic [FS_W:0]     trial;
  logic              fits;
  logic [PROD_W-1:0] num_abs;
  logic [THR_W-1:0]  q13;

  assign num_abs = req.num[PROD_W-1] ? PROD_W'(-req.num) : PROD_W'(req.num);
  assign trial   = {rem, acc[MAG_W-1]};
  assign fits    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'(DIV_STEPS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= num_abs[MAG_W-1:0];
      rem <= '0;
      den <= req.den;
      neg <= req.num[PROD_W-1];
    end else if (busy) begin
      acc <= {acc[MAG_W-2:0], fits};
      rem <= fits ? FS_W'(trial - {1'b0, den}) : trial[FS_W-1:0];
    end
  end

  assign q13      = acc[THR_W-1:0];
  assign rsp.done = done;
  assign rsp.quot = neg ? ((rem != '0) ? $signed(~q13) : $signed(-q13)) : $signed(q13);

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && $past(cnt) == '0)
    else $error("divider done without finishing its steps");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done && !req.start |-> !busy)
    else $error("divider busy while reporting done");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    busy && !$past(req.start) && den != '0 |-> rem < den)
    else $error("divider remainder not below denominator");

endmodule

FILE: hdl/thruster_mix_deadband_pwm.sv
// Top level of the thruster mixer: config registers, trip logic, sequencer, output register.
// Depends on tmd_pkg and tmd_fdiv.
//
// Usage:
//   s_* channel carries one control tick: four 11-bit commands and four 16-bit currents.
//   m_* channel returns seven 12-bit PWM counts in tdata and the trip flag in tuser.
//   cfg_we/cfg_index/cfg_data write one of eight registers per cycle; write only when idle.
// Timing:
//   s_tready is high only while the sequencer is idle. After an accepted item the
//   sequencer walks five distinct thrusts (four horizontal, one shared vertical).
//   A thrust in a linear band goes through operand latch, multiply, start,
//   22 divider steps and write-back; a saturated or deadband thrust is written directly.
//   So an item's time to its result is set by the shared 22-step divider, and the
//   sequencer takes no new item until it has loaded the last one's result.
//   A tripped tick skips the mapping and goes straight to the output register.
// Reset:
//   rst is synchronous; it restores register defaults and clears the trip and run count.
// Stall:
//   The result sits in an output register until m_tready; the next item can be taken
//   meanwhile, and its result waits in the sequencer until the output register frees.
module thruster_mix_deadband_pwm import tmd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // x_cmd, y_cmd, rot_cmd, heave_cmd, current_1, current_2, current_3, current_4
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // pwm_1, pwm_2, pwm_3, pwm_4, pwm_5, pwm_6, pwm_7
  output logic [M_TDATA_W-1:0] m_tdata,
  // tripped
  output logic [0:0]           m_tuser
);

  localparam int OUT_W = NUM_THRUSTERS * PWM_W;

  logic [7:0]       cmd_deadband;
  logic [FS_W-1:0]  full_scale;
  logic [PWM_W-1:0] pwm_min, pwm_db_low, pwm_db_high, pwm_max;
  logic [CUR_W-1:0] current_limit;
  logic [5:0]       trip_count;

  tmd_state_t state, state_next;
  logic [2:0] ch;
  logic       last_ch;

  logic signed [THR_W-1:0] thr [NUM_MAPS];
  logic [PWM_W-1:0]        res [NUM_MAPS];

  logic [FS_W-1:0]          mul_a;
  logic signed [THR_W-1:0]  mul_b;
  logic [PWM_W-1:0]         base;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W:0]   prod_full;

  logic [5:0] run;
  logic       trip;
  logic [5:0] run_inc;
  logic       over;
  logic       trip_hit;
  logic       trip_new;

  logic [OUT_W-1:0] out_pwm;
  logic             out_trip;

  logic accept, res_we, out_load, div_start;

  tmd_div_req_t div_req;
  tmd_div_rsp_t div_rsp;

  logic signed [CMD_W-1:0] x_db, y_db, r_db, h_db;
  logic signed [THR_W-1:0] x13, y13, r13, h13;

  logic signed [THR_W-1:0] v, f13;
  logic                    sel_direct;
  logic [PWM_W-1:0]        sel_val, sel_base;
  logic [FS_W-1:0]         sel_a;
  logic signed [THR_W-1:0] sel_b;
  logic [THR_W-1:0]        v_plus_f, v_minus_db, mid_sum;
  logic signed [THR_W:0]   div_sum;
  logic [PWM_W-1:0]        wr_val;

  function automatic logic signed [CMD_W-1:0] deadband(input logic [CMD_W-1:0] c,
                                                       input logic [7:0] d);
    logic signed [CMD_W:0] c12;
    logic signed [CMD_W:0] d12;
    c12 = $signed({c[CMD_W-1], c});
    d12 = $signed({4'b0000, d});
    if (c12 < d12 && c12 > -d12) begin
      return '0;
    end
    return $signed(c);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_deadband  <= 8'd7;
      full_scale    <= 10'd300;
      pwm_min       <= 12'd242;
      pwm_db_low    <= 12'd293;
      pwm_db_high   <= 12'd307;
      pwm_max       <= 12'd362;
      current_limit <= 16'd3500;
      trip_count    <= 6'd20;
    end else if (cfg_we) begin
      unique case (tmd_reg_t'(cfg_index))
        REG_CMD_DB:      cmd_deadband  <= cfg_data[7:0];
        REG_FULL_SCALE:  full_scale    <= cfg_data[FS_W-1:0];
        REG_PWM_MIN:     pwm_min       <= cfg_data[PWM_W-1:0];
        REG_PWM_DB_LOW:  pwm_db_low    <= cfg_data[PWM_W-1:0];
        REG_PWM_DB_HIGH: pwm_db_high   <= cfg_data[PWM_W-1:0];
        REG_PWM_MAX:     pwm_max       <= cfg_data[PWM_W-1:0];
        REG_CUR_LIMIT:   current_limit <= cfg_data[CUR_W-1:0];
        REG_TRIP_COUNT:  trip_count    <= cfg_data[5:0];
        default:         ;
      endcase
    end
  end

  // input decode, deadband and over-current check
  assign x_db = deadband(s_tdata[10:0], cmd_deadband);
  assign y_db = deadband(s_tdata[21:11], cmd_deadband);
  assign r_db = deadband(s_tdata[32:22], cmd_deadband);
  assign h_db = deadband(s_tdata[43:33], cmd_deadband);
  assign x13  = THR_W'(x_db);
  assign y13  = THR_W'(y_db);
  assign r13  = THR_W'(r_db);
  assign h13  = THR_W'(h_db);

  assign over = (s_tdata[59:44] > current_limit) || (s_tdata[75:60] > current_limit) ||
                (s_tdata[91:76] > current_limit) || (s_tdata[107:92] > current_limit);
  assign run_inc  = (run == 6'd63) ? run : run + 6'd1;
  assign trip_hit = !trip && over && (run_inc > trip_count);
  assign trip_new = trip || trip_hit;

  // thrust classification for the current channel
  assign v          = thr[ch];
  assign f13        = $signed({3'b000, full_scale});
  assign v_plus_f   = THR_W'(v + f13);
  assign v_minus_db = THR_W'(v - THRUST_DB);
  assign mid_sum    = {1'b0, pwm_db_low} + {1'b0, pwm_db_high};

  always_comb begin
    sel_direct = 1'b1;
    sel_val    = pwm_max;
    sel_a      = v_plus_f[FS_W-1:0];
    sel_b      = $signed({1'b0, pwm_db_low}) - $signed({1'b0, pwm_min});
    sel_base   = pwm_min;
    priority if (v < -f13) begin
      sel_val = pwm_min;
    end else if (v < -THRUST_DB) begin
      sel_val = pwm_min;
      if (full_scale > 10'd3) begin
        sel_direct = 1'b0;
      end
    end else if (v < THRUST_DB) begin
      sel_val = mid_sum[THR_W-1:1];
    end else if (v < f13) begin
      sel_val  = pwm_max;
      sel_a    = v_minus_db[FS_W-1:0];
      sel_b    = $signed({1'b0, pwm_max}) - $signed({1'b0, pwm_db_high});
      sel_base = pwm_db_high;
      if (full_scale > 10'd3) begin
        sel_direct = 1'b0;
      end
    end else begin
      sel_val = pwm_max;
    end
  end

  assign last_ch = (ch == 3'(NUM_MAPS - 1));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    res_we     = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          accept     = 1'b1;
          state_next = trip_new ? ST_DONE : ST_SEL;
        end
      end
      ST_SEL: begin
        if (sel_direct) begin
          res_we     = 1'b1;
          state_next = last_ch ? ST_DONE : ST_SEL;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        state_next = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_we     = 1'b1;
          state_next = last_ch ? ST_DONE : ST_SEL;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // trip state and channel counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= '0;
      trip <= 1'b0;
      ch   <= '0;
    end else begin
      if (accept && !trip) begin
        run <= over ? run_inc : '0;
        if (trip_hit) begin
          trip <= 1'b1;
        end
      end
      if (accept) begin
        ch <= '0;
      end else if (res_we) begin
        ch <= ch + 3'd1;
      end
    end
  end

  // datapath: mix, multiply, write back
  assign prod_full = $signed({1'b0, mul_a}) * mul_b;
  assign div_sum   = $signed({div_rsp.quot[THR_W-1], div_rsp.quot}) + $signed({2'b00, base});
  assign wr_val    = (state == ST_DIV) ? div_sum[PWM_W-1:0] : sel_val;

  always_ff @(posedge clk) begin
    if (accept) begin
      thr[0] <= x13 - y13 + r13;
      thr[1] <= x13 + y13 - r13;
      thr[2] <= -x13 - y13 - r13;
      thr[3] <= -x13 + y13 + r13;
      thr[4] <= -h13;
    end
    if (state == ST_SEL && !sel_direct) begin
      mul_a <= sel_a;
      mul_b <= sel_b;
      base  <= sel_base;
    end
    if (state == ST_MUL) begin
      prod <= prod_full[PROD_W-1:0];
    end
    if (res_we) begin
      res[ch] <= wr_val;
    end
  end

  assign div_req.start = div_start;
  assign div_req.num   = prod;
  assign div_req.den   = FS_W'(full_scale - 10'd3);

  tmd_fdiv u_fdiv (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_trip <= trip;
      for (int i = 0; i < NUM_THRUSTERS; i++) begin
        out_pwm[i*PWM_W +: PWM_W] <= trip ? STOP_COUNT :
                                     res[3'((i < NUM_MAPS) ? i : NUM_MAPS-1)];
      end
    end
  end

  assign m_tdata = {{(M_TDATA_W-OUT_W){1'b0}}, out_pwm};
  assign m_tuser = out_trip;

  a_trip_sticks: assert property (@(posedge clk) disable iff (rst)
    trip |=> trip)
    else $error("trip latch cleared without reset");

  a_trip_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[PWM_W-1:0] == STOP_COUNT)
    else $error("tripped item without stop count");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEL || state == ST_DIV |-> ch < 3'(NUM_MAPS))
    else $error("channel index out of range");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> state == ST_DIV)
    else $error("divider finished outside the wait state");

endmodule
